// ----- design/rrfp_pkg.sv -----
// Shared constants, codes and controller/datapath link types of the frame parser.
package rrfp_pkg;

  // Frame geometry
  localparam int GATE_COUNT  = 16;
  localparam int PAYLOAD_MAX = 160;

  // At most sixteen gate words go out per frame
  localparam int NGATES = (GATE_COUNT < 16) ? GATE_COUNT : 16;

  // Payload store: byte p sits in row (p+1)/4, lane (p+1)%4, so that every
  // gate word fills one row and the report bytes sit in row 0
  localparam int ROWS  = (PAYLOAD_MAX + 4) / 4;
  localparam int ROW_W = $clog2(ROWS);

  // Result sequence counter: 0 is the report, k is gate k-1
  localparam int EMIT_W = 5;
  localparam logic [EMIT_W-1:0] LAST_GATE_K = EMIT_W'(NGATES);

  // Length limits
  localparam logic [15:0] LEN_MAX        = 16'(PAYLOAD_MAX);
  localparam logic [7:0]  MIN_REPORT_LEN = 8'd3;
  localparam logic [8:0]  NEED_LEN       = 9'(3 + 4 * GATE_COUNT);

  // Markers
  localparam logic [7:0] HEAD_START = 8'hF4;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_SYNC       = 3'd0,
    KIND_BAD_LEN    = 3'd1,
    KIND_BAD_FOOTER = 3'd2,
    KIND_REPORT     = 3'd3,
    KIND_GATE       = 3'd4
  } kind_e;

  // Controller states: the parse phases and the report burst
  typedef enum logic [2:0] {
    C_HUNT,
    C_LEN_LO,
    C_LEN_HI,
    C_PAYLOAD,
    C_FOOTER,
    C_EMIT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic  marker_inc;
    logic  marker_one;
    logic  marker_clr;
    logic  len_lo_ld;
    logic  len_hi_ld;
    logic  pay_wr;
    logic  emit_start;
    logic  emit_step;
    logic  evt_ld;
    kind_e evt_kind;
  } rrfp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_hit;
    logic hdr_start;
    logic marker_wrap;
    logic ftr_hit;
    logic len_bad;
    logic pay_done;
    logic report_ok;
    logic emit_last;
    logic out_free;
  } rrfp_status_t;

  // Header byte expected at a marker position
  function automatic logic [7:0] head_mark(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = 8'hF4;
      2'd1:    m = 8'hF3;
      2'd2:    m = 8'hF2;
      default: m = 8'hF1;
    endcase
    return m;
  endfunction

  // Footer byte expected at a marker position
  function automatic logic [7:0] foot_mark(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = 8'hF8;
      2'd1:    m = 8'hF7;
      2'd2:    m = 8'hF6;
      default: m = 8'hF5;
    endcase
    return m;
  endfunction

endpackage

// ----- design/rrfp_if.sv -----
// Handshake channels of the frame parser: received bytes and parse results.
interface rrfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rrfp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        presence;
  logic [15:0] target_range;
  logic [3:0]  gate_index;
  logic [31:0] gate_power;
  logic        last;

  modport source (output valid, output kind, output presence, output target_range,
                  output gate_index, output gate_power, output last, input ready);
  modport sink   (input valid, input kind, input presence, input target_range,
                  input gate_index, input gate_power, input last, output ready);
endinterface

// ----- design/radar_report_frame_parser.sv -----
// Top level of the radar report frame parser: controller and datapath.
//
//   channel    dir  payload                                                handshake
//   byte_i     in   data_byte[7:0]                                         valid/ready
//   result_o   out  kind[2:0] presence target_range[15:0] gate_index[3:0]  valid/ready
//                   gate_power[31:0] last
//
// A byte is taken when the result register is free or being emptied.
// The final footer byte of a good frame starts a burst of one report and up to
// sixteen gate words, one per cycle while result_o is not stalled, from the payload store
// read port; byte_i.ready stays low during the burst.
// Reset clears the phase, marker, length and position; the store needs no clearing.
// A stalled result_o holds its word and blocks all further bytes.
module radar_report_frame_parser
  import rrfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rrfp_byte_if.sink   byte_i,
  rrfp_res_if.source  result_o
);

  rrfp_cmd_t    cmd;
  rrfp_status_t status;
  logic         in_ready;

  rrfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrfp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (byte_i.data_byte),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (result_o)
  );

  assign byte_i.ready = in_ready;

endmodule

// ----- design/rrfp_ctrl.sv -----
// Parse controller: frame phase state machine and report burst sequencing.
module rrfp_ctrl
  import rrfp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  rrfp_status_t status_i,
  output rrfp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        parse_st;
  logic        take;

  // Hold the phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // Take a word only in a parse phase and with room for a result
  assign parse_st   = (state_q != C_EMIT);
  assign in_ready_o = parse_st && status_i.out_free;
  assign take       = in_valid_i && in_ready_o;

  // Decide next phase and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.evt_kind = KIND_SYNC;
    case (state_q)
      C_HUNT: begin
        if (take) begin
          if (status_i.hdr_hit) begin
            cmd_o.marker_inc = 1'b1;
            if (status_i.marker_wrap) begin
              cmd_o.evt_ld   = 1'b1;
              cmd_o.evt_kind = KIND_SYNC;
              state_d        = C_LEN_LO;
            end
          end else if (status_i.hdr_start) begin
            cmd_o.marker_one = 1'b1;
          end else begin
            cmd_o.marker_clr = 1'b1;
          end
        end
      end
      C_LEN_LO: begin
        if (take) begin
          cmd_o.len_lo_ld = 1'b1;
          state_d         = C_LEN_HI;
        end
      end
      C_LEN_HI: begin
        if (take) begin
          if (status_i.len_bad) begin
            cmd_o.evt_ld     = 1'b1;
            cmd_o.evt_kind   = KIND_BAD_LEN;
            cmd_o.marker_clr = 1'b1;
            state_d          = C_HUNT;
          end else begin
            cmd_o.len_hi_ld = 1'b1;
            state_d         = C_PAYLOAD;
          end
        end
      end
      C_PAYLOAD: begin
        if (take) begin
          cmd_o.pay_wr = 1'b1;
          if (status_i.pay_done) begin
            cmd_o.marker_clr = 1'b1;
            state_d          = C_FOOTER;
          end
        end
      end
      C_FOOTER: begin
        if (take) begin
          if (!status_i.ftr_hit) begin
            cmd_o.evt_ld     = 1'b1;
            cmd_o.evt_kind   = KIND_BAD_FOOTER;
            cmd_o.marker_clr = 1'b1;
            state_d          = C_HUNT;
          end else begin
            cmd_o.marker_inc = 1'b1;
            if (status_i.marker_wrap) begin
              if (status_i.report_ok) begin
                cmd_o.emit_start = 1'b1;
                state_d          = C_EMIT;
              end else begin
                state_d = C_HUNT;
              end
            end
          end
        end
      end
      C_EMIT: begin
        // Push one report or gate word per free output slot
        if (status_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (status_i.emit_last) begin
            state_d = C_HUNT;
          end
        end
      end
      default: begin
        cmd_o.marker_clr = 1'b1;
        state_d          = C_HUNT;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // The burst always ends back in the header hunt
  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_EMIT && status_i.out_free && status_i.emit_last) |=> (state_q == C_HUNT))
    else $error("report burst did not return to header hunt");

  // A burst starts only from an accepted final footer word
  a_emit_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == C_EMIT) |-> $past(take && state_q == C_FOOTER))
    else $error("report burst entered without a footer word");

  // No word is taken during a burst
  a_emit_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_EMIT) |-> !in_ready_o)
    else $error("word taken during report burst");
`endif

endmodule

// ----- design/rrfp_dp.sv -----
// Parse datapath: marker and length registers, payload store, result register.
module rrfp_dp
  import rrfp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    data_byte_i,
  input  rrfp_cmd_t     cmd_i,
  output rrfp_status_t  status_o,
  rrfp_res_if.source    res_o
);

  logic [1:0]        marker_q;
  logic [7:0]        len_lo_q;
  logic [7:0]        len_q;
  logic [7:0]        pos_q;
  logic [EMIT_W-1:0] emit_k_q;
  logic [31:0]       mem_q [ROWS];
  logic [31:0]       rd_data_q;

  logic              out_valid_q;
  kind_e             out_kind_q;
  logic              out_pres_q;
  logic [15:0]       out_dist_q;
  logic [3:0]        out_gidx_q;
  logic [31:0]       out_energy_q;
  logic              out_last_q;

  logic [15:0]       len16;
  logic [8:0]        pos_nx;
  logic [ROW_W-1:0]  wr_row;
  logic [1:0]        wr_lane;
  logic [ROW_W-1:0]  rd_row;
  logic              rd_en;
  logic              has_gates;
  logic              emit_last;
  logic              out_free;
  logic [EMIT_W-1:0] emit_k_m1;

  // Derive status
  assign len16     = {data_byte_i, len_lo_q};
  assign pos_nx    = {1'b0, pos_q} + 9'd1;
  assign has_gates = ({1'b0, len_q} >= NEED_LEN);
  assign emit_last = has_gates ? (emit_k_q == LAST_GATE_K) : (emit_k_q == '0);
  assign out_free  = !out_valid_q || res_o.ready;

  always_comb begin
    status_o.hdr_hit     = (data_byte_i == head_mark(marker_q));
    status_o.hdr_start   = (data_byte_i == HEAD_START);
    status_o.marker_wrap = (marker_q == 2'd3);
    status_o.ftr_hit     = (data_byte_i == foot_mark(marker_q));
    status_o.len_bad     = (len16 == 16'd0) || (len16 > LEN_MAX);
    status_o.pay_done    = (pos_nx >= {1'b0, len_q});
    status_o.report_ok   = (len_q >= MIN_REPORT_LEN);
    status_o.emit_last   = emit_last;
    status_o.out_free    = out_free;
  end

  // Advance marker position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= 2'd0;
    end else if (cmd_i.marker_clr) begin
      marker_q <= 2'd0;
    end else if (cmd_i.marker_one) begin
      marker_q <= 2'd1;
    end else if (cmd_i.marker_inc) begin
      marker_q <= marker_q + 2'd1;
    end
  end

  // Capture length and step the payload position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_lo_q <= 8'd0;
      len_q    <= 8'd0;
      pos_q    <= 8'd0;
    end else begin
      if (cmd_i.len_lo_ld) begin
        len_lo_q <= data_byte_i;
      end
      if (cmd_i.len_hi_ld) begin
        len_q <= len16[7:0];
        pos_q <= 8'd0;
      end else if (cmd_i.pay_wr) begin
        pos_q <= pos_nx[7:0];
      end
    end
  end

  // Store payload bytes one lane at a time
  assign wr_row  = ROW_W'(pos_nx >> 2);
  assign wr_lane = pos_nx[1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.pay_wr) begin
      mem_q[wr_row][{wr_lane, 3'b000} +: 8] <= data_byte_i;
    end
  end

  // Read row 0 to open the burst, then the next row per result sent
  assign rd_en  = cmd_i.emit_start || (cmd_i.emit_step && !emit_last);
  assign rd_row = cmd_i.emit_start ? '0 : ROW_W'(emit_k_q + EMIT_W'(1));

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_row];
    end
  end

  // Count results in the burst; rewind after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_k_q <= '0;
    end else if (cmd_i.emit_start) begin
      emit_k_q <= '0;
    end else if (cmd_i.emit_step) begin
      emit_k_q <= emit_last ? '0 : emit_k_q + EMIT_W'(1);
    end
  end

  assign emit_k_m1 = emit_k_q - EMIT_W'(1);

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.evt_ld || cmd_i.emit_step) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.evt_ld) begin
      out_kind_q   <= cmd_i.evt_kind;
      out_pres_q   <= 1'b0;
      out_dist_q   <= 16'd0;
      out_gidx_q   <= 4'd0;
      out_energy_q <= 32'd0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_step) begin
      out_last_q <= emit_last;
      if (emit_k_q == '0) begin
        out_kind_q   <= KIND_REPORT;
        out_pres_q   <= (rd_data_q[15:8] != 8'd0);
        out_dist_q   <= rd_data_q[31:16];
        out_gidx_q   <= 4'd0;
        out_energy_q <= 32'd0;
      end else begin
        out_kind_q   <= KIND_GATE;
        out_pres_q   <= 1'b0;
        out_dist_q   <= 16'd0;
        out_gidx_q   <= emit_k_m1[3:0];
        out_energy_q <= rd_data_q;
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_kind_q;
  assign res_o.presence     = out_pres_q;
  assign res_o.target_range = out_dist_q;
  assign res_o.gate_index   = out_gidx_q;
  assign res_o.gate_power   = out_energy_q;
  assign res_o.last         = out_last_q;

`ifndef ASSERT_OFF
  // A result is loaded only into a free slot
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.evt_ld || cmd_i.emit_step) |-> out_free)
    else $error("result register overwritten while occupied");

  // Payload writes stay inside the store
  a_pay_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pay_wr |-> ({1'b0, pos_q} < 9'(PAYLOAD_MAX)))
    else $error("payload write beyond store");

  // The burst counter never passes the last gate
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_k_q <= LAST_GATE_K)
    else $error("burst counter out of range");
`endif

endmodule
